// ===== rtl/cmbs_pkg.sv =====
// Package for the cube map bilinear sampler: sizes, codes and shared types.
// Used by every module of the block but cmbs_ram; depends on nothing.
`default_nettype none

package cmbs_pkg;

    localparam int FACE_RES_MAX = 64;
    localparam int CHANNEL_BITS = 16;
    localparam int NUM_CHANNELS = 4;
    localparam int TEXEL_BITS = CHANNEL_BITS * NUM_CHANNELS;
    localparam int NUM_FACES = 6;
    localparam int FACE_BITS = 3;
    localparam int WCOORD_BITS = 6;
    localparam int COORD_BITS = $clog2(FACE_RES_MAX);
    localparam int HALF_BITS = COORD_BITS - 1;
    localparam int RES_BITS = 7;
    localparam int NUM_BANKS = 4;
    localparam int NUM_TAPS = 4;
    localparam int BANK_DEPTH = NUM_FACES * (FACE_RES_MAX / 2) * (FACE_RES_MAX / 2);
    localparam int BANK_ADDR_BITS = FACE_BITS + 2 * HALF_BITS;

    localparam int FRAC_BITS = 16;
    localparam int DIR_BITS = 16;
    localparam int ST_BITS = FRAC_BITS + 1;
    localparam int QUO_BITS = ST_BITS;
    localparam int DIV_STEP = 3;
    localparam int DIV_STAGES = (QUO_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int WEIGHT_BITS = 2 * ST_BITS - 1;
    localparam int POS_BITS = FRAC_BITS + COORD_BITS + 2;
    localparam int PROD_BITS = CHANNEL_BITS + 2 * FRAC_BITS;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_BITS-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_BITS-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_BITS-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_BITS-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_BITS-1:0] FACE_NEG_Z = 3'd5;

    typedef struct packed {
        logic                   valid;
        logic                   sample;
        logic [FACE_BITS-1:0]   face;
        logic [WCOORD_BITS-1:0] wr_x;
        logic [WCOORD_BITS-1:0] wr_y;
        logic [TEXEL_BITS-1:0]  texel;
    } cmbs_side_t;

    typedef struct packed {
        logic                 valid;
        logic [FACE_BITS-1:0] face;
        logic [ST_BITS-1:0]   s;
        logic [ST_BITS-1:0]   t;
    } cmbs_res_t;

endpackage

`default_nettype wire

// ===== rtl/cmbs_ram.sv =====
// Generic single-port RAM with a registered read port.
// Standalone; used for the texel banks of the sampler.
`default_nettype none

module cmbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 6144,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] addr,
    input  wire logic [WIDTH-1:0]     wdata,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cmbs_dir_sel.sv =====
// Input stage: registers a transaction and selects the cube face and the
// numerators for the face coordinate division. Depends on cmbs_pkg.
`default_nettype none

module cmbs_dir_sel import cmbs_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire logic                   in_valid,
    input  wire logic                   opcode,
    input  wire logic [DIR_BITS-1:0]    dir_x,
    input  wire logic [DIR_BITS-1:0]    dir_y,
    input  wire logic [DIR_BITS-1:0]    dir_z,
    input  wire logic [FACE_BITS-1:0]   write_face,
    input  wire logic [WCOORD_BITS-1:0] write_x,
    input  wire logic [WCOORD_BITS-1:0] write_y,
    input  wire logic [TEXEL_BITS-1:0]  texel,
    output cmbs_side_t                  side,
    output logic      [ST_BITS-1:0]     num_s,
    output logic      [ST_BITS-1:0]     num_t,
    output logic      [DIR_BITS-1:0]    mag
);

    logic signed [ST_BITS-1:0] ex, ey, ez, ax, ay, az, sc, tc, mg;
    logic        [FACE_BITS-1:0] hf;
    logic        [DIR_BITS-1:0] ma_c;
    logic signed [ST_BITS:0]   sum_s, sum_t;
    cmbs_side_t                side_next, side_reg;
    logic        [ST_BITS-1:0] num_s_reg, num_t_reg;
    logic        [DIR_BITS-1:0] mag_reg;

    always_comb
    begin
        ex = ST_BITS'($signed(dir_x));
        ey = ST_BITS'($signed(dir_y));
        ez = ST_BITS'($signed(dir_z));
        ax = dir_x[DIR_BITS-1] ? -ex : ex;
        ay = dir_y[DIR_BITS-1] ? -ey : ey;
        az = dir_z[DIR_BITS-1] ? -ez : ez;
        if (ax >= ay && ax >= az)
        begin
            mg = ax;
            tc = -ey;
            if (!dir_x[DIR_BITS-1])
            begin
                hf = FACE_POS_X;
                sc = -ez;
            end
            else
            begin
                hf = FACE_NEG_X;
                sc = ez;
            end
        end
        else if (ay >= az)
        begin
            mg = ay;
            sc = ex;
            if (!dir_y[DIR_BITS-1])
            begin
                hf = FACE_POS_Y;
                tc = ez;
            end
            else
            begin
                hf = FACE_NEG_Y;
                tc = -ez;
            end
        end
        else
        begin
            mg = az;
            tc = -ey;
            if (!dir_z[DIR_BITS-1])
            begin
                hf = FACE_POS_Z;
                sc = ex;
            end
            else
            begin
                hf = FACE_NEG_Z;
                sc = -ex;
            end
        end
        ma_c = (mg == '0) ? DIR_BITS'(1) : mg[DIR_BITS-1:0];
        sum_s = (ST_BITS+1)'(sc) + $signed({2'b00, ma_c});
        sum_t = (ST_BITS+1)'(tc) + $signed({2'b00, ma_c});

        side_next.valid  = in_valid;
        side_next.sample = (opcode == OP_SAMPLE);
        side_next.face   = (opcode == OP_SAMPLE) ? hf : write_face;
        side_next.wr_x   = write_x;
        side_next.wr_y   = write_y;
        side_next.texel  = texel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg  <= '0;
            num_s_reg <= '0;
            num_t_reg <= '0;
            mag_reg   <= '0;
        end
        else if (adv)
        begin
            side_reg  <= side_next;
            num_s_reg <= sum_s[ST_BITS-1:0];
            num_t_reg <= sum_t[ST_BITS-1:0];
            mag_reg   <= ma_c;
        end
    end

    assign side  = side_reg;
    assign num_s = num_s_reg;
    assign num_t = num_t_reg;
    assign mag   = mag_reg;

endmodule

`default_nettype wire

// ===== rtl/cmbs_divider.sv =====
// Pipelined restoring divider for the s and t face coordinates, DIV_STEP
// quotient bits per stage, carrying the transaction alongside. Depends on cmbs_pkg.
`default_nettype none

module cmbs_divider import cmbs_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  cmbs_side_t               side_in,
    input  wire logic [ST_BITS-1:0]  num_s,
    input  wire logic [ST_BITS-1:0]  num_t,
    input  wire logic [DIR_BITS-1:0] mag,
    output cmbs_side_t               side_out,
    output logic      [ST_BITS-1:0]  coord_s,
    output logic      [ST_BITS-1:0]  coord_t
);

    typedef struct packed {
        logic [ST_BITS-1:0]  rem;
        logic [ST_BITS-1:0]  bits;
        logic [QUO_BITS-1:0] quo;
    } div_lane_t;

    function automatic div_lane_t div_steps(input div_lane_t x, input logic [ST_BITS-1:0] d,
                                            input int base);
        div_lane_t         y;
        logic [ST_BITS:0]  tr;
        y = x;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            if (base + i < QUO_BITS)
            begin
                tr = {y.rem, y.bits[ST_BITS-1]};
                y.bits = {y.bits[ST_BITS-2:0], 1'b0};
                if (tr >= {1'b0, d})
                begin
                    tr = tr - {1'b0, d};
                    y.quo = {y.quo[QUO_BITS-2:0], 1'b1};
                end
                else
                begin
                    y.quo = {y.quo[QUO_BITS-2:0], 1'b0};
                end
                y.rem = tr[ST_BITS-1:0];
            end
        end
        return y;
    endfunction

    div_lane_t          s_src [DIV_STAGES];
    div_lane_t          t_src [DIV_STAGES];
    logic [ST_BITS-1:0] d_src [DIV_STAGES];
    cmbs_side_t         side_src [DIV_STAGES];
    div_lane_t          s_next [DIV_STAGES];
    div_lane_t          t_next [DIV_STAGES];
    div_lane_t          s_reg [DIV_STAGES];
    div_lane_t          t_reg [DIV_STAGES];
    logic [ST_BITS-1:0] d_reg [DIV_STAGES];
    cmbs_side_t         side_reg [DIV_STAGES];

    always_comb
    begin
        s_src[0]    = {1'b0, num_s[ST_BITS-1:1], num_s[0], mag, {QUO_BITS{1'b0}}};
        t_src[0]    = {1'b0, num_t[ST_BITS-1:1], num_t[0], mag, {QUO_BITS{1'b0}}};
        d_src[0]    = {mag, 1'b0};
        side_src[0] = side_in;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            s_src[k]    = s_reg[k-1];
            t_src[k]    = t_reg[k-1];
            d_src[k]    = d_reg[k-1];
            side_src[k] = side_reg[k-1];
        end
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            s_next[k] = div_steps(s_src[k], d_src[k], k * DIV_STEP);
            t_next[k] = div_steps(t_src[k], d_src[k], k * DIV_STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                s_reg[k]    <= '0;
                t_reg[k]    <= '0;
                d_reg[k]    <= '0;
                side_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                s_reg[k]    <= s_next[k];
                t_reg[k]    <= t_next[k];
                d_reg[k]    <= d_src[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign side_out = side_reg[DIV_STAGES-1];
    assign coord_s  = s_reg[DIV_STAGES-1].quo;
    assign coord_t  = t_reg[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

// ===== rtl/cmbs_fetch.sv =====
// Tap position, bilinear weights and the four parity-banked texel RAMs.
// Texel writes land here too, in order with samples. Depends on cmbs_pkg, cmbs_ram.
`default_nettype none

module cmbs_fetch import cmbs_pkg::*; (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      adv,
    input  cmbs_side_t                                     side,
    input  wire logic [ST_BITS-1:0]                        coord_s,
    input  wire logic [ST_BITS-1:0]                        coord_t,
    input  wire logic [RES_BITS-1:0]                       face_size,
    output logic      [NUM_BANKS-1:0][TEXEL_BITS-1:0]      bank_data,
    output logic      [NUM_TAPS-1:0][1:0]                  tap_bank,
    output logic      [NUM_TAPS-1:0][WEIGHT_BITS-1:0]      tap_weight,
    output cmbs_res_t                                      info
);

    logic [RES_BITS-1:0]   res;
    logic [POS_BITS-1:0]   bx, by;
    logic [COORD_BITS:0]   ix, iy;
    logic [COORD_BITS-1:0] xa_next, xb_next, ya_next, yb_next;

    cmbs_side_t            pos_side_reg;
    logic [ST_BITS-1:0]    pos_s_reg, pos_t_reg;
    logic [COORD_BITS-1:0] xa_reg, xb_reg, ya_reg, yb_reg;
    logic [FRAC_BITS-1:0]  wx_reg, wy_reg;

    logic [ST_BITS-1:0]                   wx0, wx1, wy0, wy1;
    logic [NUM_TAPS-1:0][WEIGHT_BITS-1:0] weight_next, weight_reg;
    logic [NUM_TAPS-1:0][1:0]             bank_next, bank_reg;
    cmbs_res_t                            info_next, info_reg;
    logic [NUM_BANKS-1:0]                 bank_we;

    always_comb
    begin
        if (face_size == '0)
        begin
            res = RES_BITS'(1);
        end
        else if (face_size > RES_BITS'(FACE_RES_MAX))
        begin
            res = RES_BITS'(FACE_RES_MAX);
        end
        else
        begin
            res = face_size;
        end
        bx = POS_BITS'(coord_s) * POS_BITS'(res) + POS_BITS'(1 << (FRAC_BITS - 1));
        by = POS_BITS'(coord_t) * POS_BITS'(res) + POS_BITS'(1 << (FRAC_BITS - 1));
        ix = bx[FRAC_BITS +: COORD_BITS+1];
        iy = by[FRAC_BITS +: COORD_BITS+1];
        xa_next = (ix == '0) ? '0 : COORD_BITS'(ix - 1'b1);
        ya_next = (iy == '0) ? '0 : COORD_BITS'(iy - 1'b1);
        xb_next = (ix >= (COORD_BITS+1)'(res)) ? COORD_BITS'(res - 1'b1) : COORD_BITS'(ix);
        yb_next = (iy >= (COORD_BITS+1)'(res)) ? COORD_BITS'(res - 1'b1) : COORD_BITS'(iy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_side_reg <= '0;
            pos_s_reg    <= '0;
            pos_t_reg    <= '0;
            xa_reg       <= '0;
            xb_reg       <= '0;
            ya_reg       <= '0;
            yb_reg       <= '0;
            wx_reg       <= '0;
            wy_reg       <= '0;
        end
        else if (adv)
        begin
            pos_side_reg <= side;
            pos_s_reg    <= coord_s;
            pos_t_reg    <= coord_t;
            xa_reg       <= xa_next;
            xb_reg       <= xb_next;
            ya_reg       <= ya_next;
            yb_reg       <= yb_next;
            wx_reg       <= bx[FRAC_BITS-1:0];
            wy_reg       <= by[FRAC_BITS-1:0];
        end
    end

    always_comb
    begin
        wx1 = {1'b0, wx_reg};
        wy1 = {1'b0, wy_reg};
        wx0 = ST_BITS'(1 << FRAC_BITS) - wx1;
        wy0 = ST_BITS'(1 << FRAC_BITS) - wy1;
        weight_next[0] = WEIGHT_BITS'(wx0 * wy0);
        weight_next[1] = WEIGHT_BITS'(wx1 * wy0);
        weight_next[2] = WEIGHT_BITS'(wx0 * wy1);
        weight_next[3] = WEIGHT_BITS'(wx1 * wy1);
        bank_next[0] = {ya_reg[0], xa_reg[0]};
        bank_next[1] = {ya_reg[0], xb_reg[0]};
        bank_next[2] = {yb_reg[0], xa_reg[0]};
        bank_next[3] = {yb_reg[0], xb_reg[0]};
        info_next.valid = pos_side_reg.valid && pos_side_reg.sample;
        info_next.face  = pos_side_reg.face;
        info_next.s     = pos_s_reg;
        info_next.t     = pos_t_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
            bank_reg   <= '0;
            info_reg   <= '0;
        end
        else if (adv)
        begin
            weight_reg <= weight_next;
            bank_reg   <= bank_next;
            info_reg   <= info_next;
        end
    end

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        logic [COORD_BITS-1:0]     col, row;
        logic [BANK_ADDR_BITS-1:0] raddr, waddr;

        always_comb
        begin
            col = (xa_reg[0] == b[0]) ? xa_reg : xb_reg;
            row = (ya_reg[0] == b[1]) ? ya_reg : yb_reg;
            raddr = {pos_side_reg.face, row[COORD_BITS-1:1], col[COORD_BITS-1:1]};
            waddr = {pos_side_reg.face, pos_side_reg.wr_y[COORD_BITS-1:1],
                     pos_side_reg.wr_x[COORD_BITS-1:1]};
            bank_we[b] = pos_side_reg.valid && !pos_side_reg.sample
                         && (pos_side_reg.face < FACE_BITS'(NUM_FACES))
                         && (pos_side_reg.wr_y[0] == b[1]) && (pos_side_reg.wr_x[0] == b[0]);
        end

        cmbs_ram #(
            .WIDTH (TEXEL_BITS),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .en    (adv),
            .we    (bank_we[b]),
            .addr  (bank_we[b] ? waddr : raddr),
            .wdata (pos_side_reg.texel),
            .rdata (bank_data[b])
        );
    end

    assign tap_bank   = bank_reg;
    assign tap_weight = weight_reg;
    assign info       = info_reg;

    a_one_bank_written: assert property (
        @(posedge clk) disable iff (!rst_n) $onehot0(bank_we))
        else $error("texel write hits more than one bank");

endmodule

`default_nettype wire

// ===== rtl/cmbs_blend.sv =====
// Bilinear blend: selects each tap from its bank, weights it, sums the four
// taps with rounding and holds the result register. Depends on cmbs_pkg.
`default_nettype none

module cmbs_blend import cmbs_pkg::*; (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 adv,
    input  wire logic [NUM_BANKS-1:0][TEXEL_BITS-1:0] bank_data,
    input  wire logic [NUM_TAPS-1:0][1:0]             tap_bank,
    input  wire logic [NUM_TAPS-1:0][WEIGHT_BITS-1:0] tap_weight,
    input  cmbs_res_t                                 info,
    output logic                                      res_valid,
    output logic      [FACE_BITS-1:0]                 res_face,
    output logic      [ST_BITS-1:0]                   res_s,
    output logic      [ST_BITS-1:0]                   res_t,
    output logic      [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] res_chan
);

    logic [NUM_TAPS-1:0][NUM_CHANNELS-1:0][PROD_BITS-1:0] prod_next, prod_reg;
    cmbs_res_t                                            info_reg;
    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0]            chan_next, chan_reg;
    logic [PROD_BITS+1:0]                                 sum;
    logic [TEXEL_BITS-1:0]                                tap;
    cmbs_res_t                                            out_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_TAPS; k++)
        begin
            tap = bank_data[tap_bank[k]];
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                prod_next[k][c] = PROD_BITS'(tap[c*CHANNEL_BITS +: CHANNEL_BITS]
                                            * tap_weight[k]);
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            sum = (PROD_BITS+2)'(prod_reg[0][c]) + (PROD_BITS+2)'(prod_reg[1][c])
                  + (PROD_BITS+2)'(prod_reg[2][c]) + (PROD_BITS+2)'(prod_reg[3][c])
                  + (PROD_BITS+2)'(64'd1 << (2 * FRAC_BITS - 1));
            chan_next[c] = sum[2*FRAC_BITS +: CHANNEL_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            info_reg <= '0;
            chan_reg <= '0;
            out_reg  <= '0;
        end
        else if (adv)
        begin
            prod_reg <= prod_next;
            info_reg <= info;
            chan_reg <= chan_next;
            out_reg  <= info_reg;
        end
    end

    assign res_valid = out_reg.valid;
    assign res_face  = out_reg.face;
    assign res_s     = out_reg.s;
    assign res_t     = out_reg.t;
    assign res_chan  = chan_reg;

endmodule

`default_nettype wire

// ===== rtl/cube_map_bilinear_sampler_top.sv =====
// Top level of the cube map bilinear sampler.
// Depends on cmbs_pkg, cmbs_dir_sel, cmbs_divider, cmbs_fetch and cmbs_blend.
//
// The input channel (in_valid, in_stall) carries one transaction per item: a
// texel write (opcode 0) or a sample along a direction (opcode 1). A write
// gives no result; a sample gives one transaction on the output channel
// (out_valid, out_stall) with the hit face, s, t and the four filtered channels.
// The user must write the face size register through cfg_we and cfg_data only
// while the block is idle; the block does not enforce this. It resets to 64.
// The pipeline takes one transaction per cycle while no stalled result holds it.
// A sample passes the input, divider (three quotient bits each), tap position,
// bank read, product and result registers; the divider stages are most of these.
// Texel writes reach the texel banks at the same stage that samples read them,
// so a sample sees every write accepted before it.
// When out_stall holds a valid result, the whole pipeline freezes and in_stall
// rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and sets the face size to 64; the texel store holds no
// defined value until written and needs no clearing.
`default_nettype none

module cube_map_bilinear_sampler_top import cmbs_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [RES_BITS-1:0]     cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    opcode,
    input  wire logic [DIR_BITS-1:0]     dir_x,
    input  wire logic [DIR_BITS-1:0]     dir_y,
    input  wire logic [DIR_BITS-1:0]     dir_z,
    input  wire logic [FACE_BITS-1:0]    write_face,
    input  wire logic [WCOORD_BITS-1:0]  write_x,
    input  wire logic [WCOORD_BITS-1:0]  write_y,
    input  wire logic [CHANNEL_BITS-1:0] in_red,
    input  wire logic [CHANNEL_BITS-1:0] in_green,
    input  wire logic [CHANNEL_BITS-1:0] in_blue,
    input  wire logic [CHANNEL_BITS-1:0] in_alpha,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic      [FACE_BITS-1:0]    hit_face,
    output logic      [ST_BITS-1:0]      coord_s,
    output logic      [ST_BITS-1:0]      coord_t,
    output logic      [CHANNEL_BITS-1:0] out_red,
    output logic      [CHANNEL_BITS-1:0] out_green,
    output logic      [CHANNEL_BITS-1:0] out_blue,
    output logic      [CHANNEL_BITS-1:0] out_alpha
);

    logic                                      adv;
    logic [RES_BITS-1:0]                       face_size_reg;
    cmbs_side_t                                dir_side, div_side;
    logic [ST_BITS-1:0]                        num_s, num_t, div_s, div_t;
    logic [DIR_BITS-1:0]                       mag;
    logic [NUM_BANKS-1:0][TEXEL_BITS-1:0]      bank_data;
    logic [NUM_TAPS-1:0][1:0]                  tap_bank;
    logic [NUM_TAPS-1:0][WEIGHT_BITS-1:0]      tap_weight;
    cmbs_res_t                                 info;
    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] chan;

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_size_reg <= RES_BITS'(FACE_RES_MAX);
        end
        else if (cfg_we)
        begin
            face_size_reg <= cfg_data;
        end
    end

    cmbs_dir_sel u_dir_sel (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (in_valid),
        .opcode     (opcode),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .write_face (write_face),
        .write_x    (write_x),
        .write_y    (write_y),
        .texel      ({in_alpha, in_blue, in_green, in_red}),
        .side       (dir_side),
        .num_s      (num_s),
        .num_t      (num_t),
        .mag        (mag)
    );

    cmbs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .side_in  (dir_side),
        .num_s    (num_s),
        .num_t    (num_t),
        .mag      (mag),
        .side_out (div_side),
        .coord_s  (div_s),
        .coord_t  (div_t)
    );

    cmbs_fetch u_fetch (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .side       (div_side),
        .coord_s    (div_s),
        .coord_t    (div_t),
        .face_size  (face_size_reg),
        .bank_data  (bank_data),
        .tap_bank   (tap_bank),
        .tap_weight (tap_weight),
        .info       (info)
    );

    cmbs_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .bank_data  (bank_data),
        .tap_bank   (tap_bank),
        .tap_weight (tap_weight),
        .info       (info),
        .res_valid  (out_valid),
        .res_face   (hit_face),
        .res_s      (coord_s),
        .res_t      (coord_t),
        .res_chan   (chan)
    );

    assign out_red   = chan[0];
    assign out_green = chan[1];
    assign out_blue  = chan[2];
    assign out_alpha = chan[3];

    a_stall_only_on_backpressure: assert property (
        @(posedge clk) disable iff (!rst_n) in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    a_face_in_range: assert property (
        @(posedge clk) disable iff (!rst_n) out_valid |-> hit_face < FACE_BITS'(NUM_FACES))
        else $error("result carries an invalid face");

    a_coord_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> coord_s <= ST_BITS'(1 << FRAC_BITS) && coord_t <= ST_BITS'(1 << FRAC_BITS))
        else $error("face coordinate above one");

    a_result_frozen_when_stalled: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(coord_s) && $stable(out_red) && $stable(out_alpha))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== tb/sv/cube_map_bilinear_sampler_top_tb.sv =====
// Testbench for cube_map_bilinear_sampler_top: texel writes and direction samples
// are sent with random gaps and stalls and checked against a built-in predictor.
// Depends on cmbs_pkg and the cube_map_bilinear_sampler_top RTL.
`timescale 1ns / 100ps

module cube_map_bilinear_sampler_top_tb;
    import cmbs_pkg::*;

    typedef struct {
        logic [FACE_BITS-1:0]    face;
        logic [ST_BITS-1:0]      s;
        logic [ST_BITS-1:0]      t;
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic [CHANNEL_BITS-1:0] alpha;
    } sample_result_t;

    localparam int STORE_SIZE = NUM_FACES * FACE_RES_MAX * FACE_RES_MAX;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [RES_BITS-1:0]     cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    opcode;
    logic [DIR_BITS-1:0]     dir_x;
    logic [DIR_BITS-1:0]     dir_y;
    logic [DIR_BITS-1:0]     dir_z;
    logic [FACE_BITS-1:0]    write_face;
    logic [WCOORD_BITS-1:0]  write_x;
    logic [WCOORD_BITS-1:0]  write_y;
    logic [CHANNEL_BITS-1:0] in_red;
    logic [CHANNEL_BITS-1:0] in_green;
    logic [CHANNEL_BITS-1:0] in_blue;
    logic [CHANNEL_BITS-1:0] in_alpha;
    logic                    out_valid;
    logic                    out_stall;
    logic [FACE_BITS-1:0]    hit_face;
    logic [ST_BITS-1:0]      coord_s;
    logic [ST_BITS-1:0]      coord_t;
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
    logic [CHANNEL_BITS-1:0] out_alpha;

    logic [TEXEL_BITS-1:0] texel_mem [STORE_SIZE];
    bit                    texel_written [STORE_SIZE];
    int unsigned           face_size_reg;
    sample_result_t        pending_samples [$];
    int                    mismatches;
    bit                    idle_on;
    int                    hold_req;
    int                    stall_left;

    cube_map_bilinear_sampler_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .write_face(write_face), .write_x(write_x), .write_y(write_y),
        .in_red(in_red), .in_green(in_green), .in_blue(in_blue), .in_alpha(in_alpha),
        .out_valid(out_valid), .out_stall(out_stall), .hit_face(hit_face),
        .coord_s(coord_s), .coord_t(coord_t), .out_red(out_red),
        .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha)
    );

    always #2 clk = ~clk;

    function automatic int effective_res();
        if (face_size_reg < 1)
            return 1;
        if (face_size_reg > FACE_RES_MAX)
            return FACE_RES_MAX;
        return int'(face_size_reg);
    endfunction

    function automatic longint face_coord(longint c, longint ma);
        return ((c + ma) * 65536 + ma) / (2 * ma);
    endfunction

    function automatic int clamp_index(longint v, int res);
        if (v < 0)
            return 0;
        if (v >= res)
            return res - 1;
        return int'(v);
    endfunction

    // Resolves a direction into face, s, t, the four tap addresses and the weights.
    function automatic void map_direction(input logic [DIR_BITS-1:0] vx, vy, vz,
                                          output logic [FACE_BITS-1:0] face,
                                          output longint s, t,
                                          output int taps [4],
                                          output longint unsigned wts [4]);
        longint dx, dy, dz, ax, ay, az, sc, tc, ma, bx, by, x0, y0;
        longint unsigned wx, wy;
        int res;
        dx = longint'($signed(vx));
        dy = longint'($signed(vy));
        dz = longint'($signed(vz));
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        az = dz < 0 ? -dz : dz;
        if (ax >= ay && ax >= az) begin
            ma = ax;
            face = dx >= 0 ? FACE_POS_X : FACE_NEG_X;
            sc = dx >= 0 ? -dz : dz;
            tc = -dy;
        end
        else if (ay >= az) begin
            ma = ay;
            face = dy >= 0 ? FACE_POS_Y : FACE_NEG_Y;
            sc = dx;
            tc = dy >= 0 ? dz : -dz;
        end
        else begin
            ma = az;
            face = dz >= 0 ? FACE_POS_Z : FACE_NEG_Z;
            sc = dz >= 0 ? dx : -dx;
            tc = -dy;
        end
        if (ma < 1)
            ma = 1;
        s = face_coord(sc, ma);
        t = face_coord(tc, ma);
        res = effective_res();
        bx = s * res - 32768 + 65536;
        by = t * res - 32768 + 65536;
        x0 = (bx >>> 16) - 1;
        y0 = (by >>> 16) - 1;
        wx = bx & 16'hFFFF;
        wy = by & 16'hFFFF;
        for (int j = 0; j < 2; j++)
            for (int i = 0; i < 2; i++) begin
                taps[j*2+i] = int'((int'(face) * FACE_RES_MAX + clamp_index(y0 + j, res))
                                   * FACE_RES_MAX + clamp_index(x0 + i, res));
                wts[j*2+i] = (i ? wx : 65536 - wx) * (j ? wy : 65536 - wy);
            end
    endfunction

    function automatic sample_result_t predict_sample(logic [DIR_BITS-1:0] vx, vy, vz);
        sample_result_t r;
        longint s, t;
        int taps [4];
        longint unsigned wts [4];
        longint unsigned acc [4];
        map_direction(vx, vy, vz, r.face, s, t, taps, wts);
        r.s = s[ST_BITS-1:0];
        r.t = t[ST_BITS-1:0];
        for (int c = 0; c < 4; c++) begin
            acc[c] = 0;
            for (int k = 0; k < 4; k++)
                acc[c] += longint'(texel_mem[taps[k]][c*CHANNEL_BITS +: CHANNEL_BITS]) * wts[k];
            acc[c] = (acc[c] + 64'h8000_0000) >> 32;
        end
        r.red = acc[0][15:0];
        r.green = acc[1][15:0];
        r.blue = acc[2][15:0];
        r.alpha = acc[3][15:0];
        return r;
    endfunction

    function automatic int random_gap();
        if (!idle_on || $urandom_range(3) != 0)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [CHANNEL_BITS-1:0] random_channel();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return CHANNEL_BITS'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [DIR_BITS-1:0] vx, vy, vz,
                             input logic [FACE_BITS-1:0] wf,
                             input logic [WCOORD_BITS-1:0] wx, wy,
                             input logic [TEXEL_BITS-1:0] texel);
        int gap;
        int addr;
        gap = random_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        opcode <= op;
        dir_x <= vx;
        dir_y <= vy;
        dir_z <= vz;
        write_face <= wf;
        write_x <= wx;
        write_y <= wy;
        {in_alpha, in_blue, in_green, in_red} <= texel;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_WRITE) begin
            if (wf < NUM_FACES) begin
                addr = (int'(wf) * FACE_RES_MAX + int'(wy)) * FACE_RES_MAX + int'(wx);
                texel_mem[addr] = texel;
                texel_written[addr] = 1'b1;
            end
        end
        else
            pending_samples.push_back(predict_sample(vx, vy, vz));
    endtask

    task automatic write_texel(input logic [FACE_BITS-1:0] wf,
                               input logic [WCOORD_BITS-1:0] wx, wy);
        send_item(OP_WRITE, DIR_BITS'($urandom), DIR_BITS'($urandom), DIR_BITS'($urandom),
                  wf, wx, wy,
                  {random_channel(), random_channel(), random_channel(), random_channel()});
    endtask

    // Any tap that was never written is filled first, so the sample stays legal.
    task automatic sample_dir(input logic [DIR_BITS-1:0] vx, vy, vz);
        logic [FACE_BITS-1:0] face;
        longint s, t;
        int taps [4];
        longint unsigned wts [4];
        map_direction(vx, vy, vz, face, s, t, taps, wts);
        for (int k = 0; k < 4; k++)
            if (!texel_written[taps[k]])
                write_texel(face, WCOORD_BITS'(taps[k] % FACE_RES_MAX),
                            WCOORD_BITS'((taps[k] / FACE_RES_MAX) % FACE_RES_MAX));
        send_item(OP_SAMPLE, vx, vy, vz, FACE_BITS'($urandom), WCOORD_BITS'($urandom),
                  WCOORD_BITS'($urandom), {$urandom, $urandom});
    endtask

    task automatic set_face_size(input logic [RES_BITS-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (16) @(negedge clk);
        cfg_data <= value;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        face_size_reg = 32'(value);
    endtask

    task automatic random_sample();
        logic [DIR_BITS-1:0] m;
        case ($urandom_range(3))
            0: sample_dir(DIR_BITS'($urandom), DIR_BITS'($urandom), DIR_BITS'($urandom));
            1: sample_dir(DIR_BITS'($urandom_range(16) - 8), DIR_BITS'($urandom_range(16) - 8),
                          DIR_BITS'($urandom_range(16) - 8));
            default: begin
                m = DIR_BITS'($urandom_range(32767, 1));
                case ($urandom_range(2))
                    0: sample_dir($urandom_range(1) ? m : -m, $urandom_range(1) ? m : -m,
                                  $urandom_range(1) ? m - DIR_BITS'($urandom_range(3)) : -m);
                    1: sample_dir($urandom_range(1) ? m : -m, $urandom_range(1) ? -m : m,
                                  DIR_BITS'($urandom));
                    default: sample_dir(DIR_BITS'($urandom), $urandom_range(1) ? m : -m,
                                        $urandom_range(1) ? m : -m);
                endcase
            end
        endcase
    endtask

    task automatic test_directed();
        write_texel(3'd6, 6'd0, 6'd63);
        write_texel(3'd7, 6'd63, 6'd0);
        sample_dir(16'h0000, 16'h0000, 16'h0000);
        sample_dir(16'h7FFF, 16'h0000, 16'h0000);
        sample_dir(16'h8000, 16'h0000, 16'h0000);
        sample_dir(16'h0000, 16'h7FFF, 16'h0000);
        sample_dir(16'h0000, 16'h8000, 16'h0000);
        sample_dir(16'h0000, 16'h0000, 16'h7FFF);
        sample_dir(16'h0000, 16'h0000, 16'h8000);
        sample_dir(16'd1000, 16'd1000, 16'd1000);
        sample_dir(-16'sd500, 16'd500, 16'd0);
        sample_dir(16'd0, 16'd700, -16'sd700);
        sample_dir(16'h7FFF, 16'h8000, 16'h7FFF);
        sample_dir(16'h8000, 16'h8001, 16'h7FFF);
        sample_dir(16'h0001, 16'hFFFF, 16'h0000);
        sample_dir(16'd300, 16'd300, -16'sd300);
    endtask

    task automatic test_random_phase(input int count);
        repeat (count) begin
            if ($urandom_range(4) < 2)
                write_texel(FACE_BITS'($urandom), WCOORD_BITS'($urandom),
                            WCOORD_BITS'($urandom));
            else
                random_sample();
        end
    endtask

    task automatic test_face_sizes();
        logic [RES_BITS-1:0] sizes [6];
        sizes = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd64, 7'd33};
        foreach (sizes[i]) begin
            set_face_size(sizes[i]);
            idle_on = (i != 3);
            test_random_phase(20);
        end
        idle_on = 1'b1;
        set_face_size(RES_BITS'($urandom_range(63, 3)));
        test_random_phase(20);
    endtask

    task automatic test_backpressure();
        hold_req = 120;
        idle_on = 1'b0;
        repeat (24)
            random_sample();
        idle_on = 1'b1;
    endtask

    always @(negedge clk) begin
        if (hold_req > 0) begin
            stall_left = hold_req;
            hold_req = 0;
        end
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(3) == 0) begin
            out_stall <= 1'b1;
            stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk) begin
        sample_result_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected transaction: face %0d s %0d t %0d",
                             hit_face, coord_s, coord_t);
            end
            else begin
                e = pending_samples.pop_front();
                if (hit_face !== e.face || coord_s !== e.s || coord_t !== e.t ||
                    out_red !== e.red || out_green !== e.green ||
                    out_blue !== e.blue || out_alpha !== e.alpha) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d %0d %0d %h %h %h %h, got %0d %0d %0d %h %h %h %h",
                                 e.face, e.s, e.t, e.red, e.green, e.blue, e.alpha,
                                 hit_face, coord_s, coord_t, out_red, out_green,
                                 out_blue, out_alpha);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_WRITE;
        dir_x = '0;
        dir_y = '0;
        dir_z = '0;
        write_face = '0;
        write_x = '0;
        write_y = '0;
        {in_alpha, in_blue, in_green, in_red} = '0;
        out_stall = 1'b0;
        mismatches = 0;
        idle_on = 1'b1;
        hold_req = 0;
        stall_left = 0;
        face_size_reg = FACE_RES_MAX;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_face_sizes();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cmbs_pkg.sv
rtl/cmbs_ram.sv
rtl/cmbs_dir_sel.sv
rtl/cmbs_divider.sv
rtl/cmbs_fetch.sv
rtl/cmbs_blend.sv
rtl/cube_map_bilinear_sampler_top.sv
tb/sv/cube_map_bilinear_sampler_top_tb.sv
